### rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// Shared constants, tables and permutation functions for the DES pipeline.
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int NUM_ROUNDS = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CIPHER_KEY   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } t_reg_idx;

    // Per-stage control that travels with each beat.
    typedef struct packed {
        logic valid;
    } t_stage_ctl;

    localparam int ROT_TAB [NUM_ROUNDS] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam int IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

    localparam int IPINV_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

    localparam int E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};

    localparam int P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

    localparam int PC1_TAB [56] = '{
        57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

    localparam int PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};

    localparam logic [3:0] S_TAB [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // Bit 1 of each table is the MSB.
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-IP_TAB[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_ipinv(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-IPINV_TAB[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-PC1_TAB[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-PC2_TAB[i]];
        return r;
    endfunction

    // Rotate both 28-bit halves left by n.
    function automatic logic [55:0] rot_cd(input logic [55:0] cd, input int n);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        for (int j = 0; j < n; j++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
        end
        return {c, d};
    endfunction

    // Feistel function: E, key mix, S-boxes, P.
    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] ex;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) ex[47-i] = r[32-E_TAB[i]];
        ex = ex ^ k;
        for (int i = 0; i < 8; i++) begin
            six = ex[47-6*i -: 6];
            s[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-P_TAB[i]];
        return p;
    endfunction

endpackage

### rtl/des_key_sched.sv
// ----------------------------------------------------------------------------
// des_key_sched
// Key and decrypt-mode registers and round-key table; recomputed when either is written.
// ----------------------------------------------------------------------------
module des_key_sched import des_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [47:0]           o_round_key [NUM_ROUNDS]
);

    logic [63:0] r_key;
    logic        r_decrypt;
    logic [55:0] cd [NUM_ROUNDS+1];
    logic [47:0] rk [NUM_ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CIPHER_KEY:   r_key     <= i_cfg_data;
                REG_DECRYPT_MODE: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Static per-key logic; the key is to change only while idle, a rule on the user that the block does not enforce.
    always_comb begin
        cd[0] = perm_pc1(r_key);
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            cd[i+1] = rot_cd(cd[i], ROT_TAB[i]);
            rk[i]   = perm_pc2(cd[i+1]);
        end
        for (int i = 0; i < NUM_ROUNDS; i++)
            o_round_key[i] = r_decrypt ? rk[NUM_ROUNDS-1-i] : rk[i];
    end

endmodule

### rtl/des_round.sv
// ----------------------------------------------------------------------------
// des_round
// One registered Feistel round with valid and stall handling.
// ----------------------------------------------------------------------------
module des_round import des_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_stage_ctl  i_ctl,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    input  logic [47:0] i_key,
    output t_stage_ctl  o_ctl,
    output logic [31:0] o_left,
    output logic [31:0] o_right
);

    t_stage_ctl  r_ctl;
    logic [31:0] r_left;
    logic [31:0] r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ctl <= '0;
        else if (i_adv) r_ctl <= i_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_left  <= i_right;
            r_right <= i_left ^ feistel(i_right, i_key);
        end
    end

    assign o_ctl   = r_ctl;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

### rtl/des_block_cipher.sv
// ----------------------------------------------------------------------------
// des_block_cipher
// Sixteen-stage pipelined DES, one block per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in      | in  | i_valid / o_ready   | i_data_block[63:0]
//  out     | out | o_valid / i_ready   | o_result_block[63:0]
//  cfg     | in  | i_cfg_we            | i_cfg_idx, i_cfg_data[63:0]
//
// Each block passes through one register per Feistel round plus the output
// register, which holds the swap and inverse IP. Throughput is one beat per
// cycle unless the output stalls. A stage advances when the stage after it is
// empty or advancing, so bubbles are squeezed out; the input stalls only when
// every stage holds a beat and the output beat is not taken.
// Reset clears the valid bits and sets key and mode to zero.
// ----------------------------------------------------------------------------
module des_block_cipher import des_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [63:0]           i_data_block,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_result_block,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [47:0] round_key [NUM_ROUNDS];
    t_stage_ctl  ctl   [NUM_ROUNDS+1];
    logic [31:0] left  [NUM_ROUNDS+1];
    logic [31:0] right [NUM_ROUNDS+1];
    logic        adv   [NUM_ROUNDS+1];
    logic [63:0] ip_blk;
    logic        r_out_valid;
    logic [63:0] r_out_block;

    des_key_sched u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_round_key (round_key)
    );

    assign ip_blk      = perm_ip(i_data_block);
    assign ctl[0].valid = i_valid;
    assign left[0]     = ip_blk[63:32];
    assign right[0]    = ip_blk[31:0];

    // adv[i]: register after round i may load. Ripples back from the output.
    always_comb begin
        adv[NUM_ROUNDS] = !r_out_valid || i_ready;
        for (int i = NUM_ROUNDS - 1; i >= 0; i--)
            adv[i] = adv[i+1] || !ctl[i+1].valid;
    end
    assign o_ready = adv[0];

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        des_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv[g]),
            .i_ctl   (ctl[g]),
            .i_left  (left[g]),
            .i_right (right[g]),
            .i_key   (round_key[g]),
            .o_ctl   (ctl[g+1]),
            .o_left  (left[g+1]),
            .o_right (right[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (adv[NUM_ROUNDS]) r_out_valid <= ctl[NUM_ROUNDS].valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv[NUM_ROUNDS])
            r_out_block <= perm_ipinv({right[NUM_ROUNDS], left[NUM_ROUNDS]});
    end

    assign o_valid        = r_out_valid;
    assign o_result_block = r_out_block;

endmodule

### rtl/des_checker.sv
// ----------------------------------------------------------------------------
// des_checker
// Port-level checks on the cipher's output channel and backpressure.
// ----------------------------------------------------------------------------
module des_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_block
);

    // Output beat holds while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_block))
        else $error("output beat changed while stalled");

    // Free output always allows input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // Output taken implies input can be taken.
    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input blocked while output drains");

    // No result appears right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind des_block_cipher des_checker u_des_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result_block (o_result_block)
);
